[sv/conv2d_valid_5x5_stream_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the streaming 5x5 convolution
// Concurrent assertion helpers on clk_i with rst_ni as the disable condition.
// ----------------------------------------------------------------------------
`ifndef CONV2D_VALID_5X5_STREAM_ASSERT_SVH
`define CONV2D_VALID_5X5_STREAM_ASSERT_SVH

`ifndef SYNTHESIS

`define CV_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");

`define CV_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");

`else

`define CV_ASSERT_IMP(name, pre, post)

`define CV_ASSERT_NXT(name, pre, post)

`endif

`endif

[sv/cv2d_pkg.sv]
// ----------------------------------------------------------------------------
// Streaming convolution package
// Field widths and request codes shared by the convolution block.
// ----------------------------------------------------------------------------
package cv2d_pkg;

  localparam int PIX_W   = 8;
  localparam int COEF_W  = 16;
  localparam int IDX_W   = 5;
  localparam int SUM_W   = 29;
  localparam int COORD_W = 5;
  localparam int PROD_W  = 24;

  localparam logic CMD_COEF  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

endpackage

[sv/conv2d_valid_5x5_stream.sv]
// ----------------------------------------------------------------------------
// Streaming valid 2D convolution with a 5x5 kernel
// A result passes the input stage, the product, row-sum and output registers.
// Throughput: one request per cycle, set by the line memory, which takes one
// read and one write per cycle; a stalled output holds the pipeline back.
// Reset clears the pixel position and all valid flags and loads the kernel
// with a one in the center tap; line memory and window are not cleared.
// ----------------------------------------------------------------------------
`include "conv2d_valid_5x5_stream_assert.svh"

module conv2d_valid_5x5_stream #(
  parameter int IMAGE_SIZE = 28,
  parameter int KERNEL_DIM = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                command_i,
  input  logic [cv2d_pkg::PIX_W-1:0]          pixel_i,
  input  logic [cv2d_pkg::IDX_W-1:0]          coef_index_i,
  input  logic signed [cv2d_pkg::COEF_W-1:0]  coef_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [cv2d_pkg::SUM_W-1:0]   sum_o,
  output logic [cv2d_pkg::COORD_W-1:0]        out_row_o,
  output logic [cv2d_pkg::COORD_W-1:0]        out_col_o,
  output logic                                frame_end_o
);

  import cv2d_pkg::*;

  localparam int TAPS    = KERNEL_DIM * KERNEL_DIM;
  localparam int CENTER  = (KERNEL_DIM / 2) * KERNEL_DIM + (KERNEL_DIM / 2);
  localparam int CNT_W   = $clog2(IMAGE_SIZE);
  localparam int EXT_W   = (CNT_W > COORD_W) ? CNT_W : COORD_W;
  localparam int LINE_W  = KERNEL_DIM * PIX_W;
  localparam int CLG     = $clog2(KERNEL_DIM);
  localparam int ROW_W   = PROD_W + CLG;
  localparam int TOT_RAW = PROD_W + 2 * CLG;
  localparam int TOT_W   = (TOT_RAW > SUM_W) ? TOT_RAW : SUM_W;

  logic in_acc, pix_acc, coef_we;
  logic rdy2, rdy3, rdy4;
  logic s1_adv, s1_emit, s1_last;

  logic [CNT_W-1:0] col_q, col_d, row_q, row_d;

  logic [LINE_W-1:0] line_mem [IMAGE_SIZE];
  logic [LINE_W-1:0] rdata_q;
  logic [LINE_W-1:0] col_word;

  logic              s1_valid_q;
  logic [CNT_W-1:0]  s1_row_q, s1_col_q;
  logic [PIX_W-1:0]  s1_pix_q;
  logic [EXT_W-1:0]  s1_orow_ext, s1_ocol_ext;

  logic [PIX_W-1:0] win_q [KERNEL_DIM][KERNEL_DIM];
  logic [PIX_W-1:0] win_d [KERNEL_DIM][KERNEL_DIM];

  logic signed [COEF_W-1:0] kern_q [TAPS];

  logic                     s2_valid_q, s2_last_q;
  logic [COORD_W-1:0]       s2_row_q, s2_col_q;
  logic signed [PROD_W-1:0] prod_d [KERNEL_DIM][KERNEL_DIM];
  logic signed [PROD_W-1:0] prod_q [KERNEL_DIM][KERNEL_DIM];

  logic                     s3_valid_q, s3_last_q;
  logic [COORD_W-1:0]       s3_row_q, s3_col_q;
  logic signed [ROW_W-1:0]  rsum_d [KERNEL_DIM];
  logic signed [ROW_W-1:0]  rsum_q [KERNEL_DIM];

  logic                     out_valid_q, out_last_q;
  logic [COORD_W-1:0]       out_row_q, out_col_q;
  logic signed [TOT_W-1:0]  total_d;
  logic signed [SUM_W-1:0]  sum_q;

  // Pipeline flow control.
  assign rdy4       = !out_valid_q || out_ready_i;
  assign rdy3       = !s3_valid_q || rdy4;
  assign rdy2       = !s2_valid_q || rdy3;
  assign s1_adv     = s1_valid_q && (!s1_emit || rdy2);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign pix_acc    = in_acc && (command_i == CMD_PIXEL);
  assign coef_we    = in_acc && (command_i == CMD_COEF);

  // Raster position of the next pixel.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (pix_acc) begin
      if (col_q == CNT_W'(IMAGE_SIZE - 1)) begin
        col_d = '0;
        row_d = (row_q == CNT_W'(IMAGE_SIZE - 1)) ? '0 : row_q + CNT_W'(1);
      end else begin
        col_d = col_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Each line memory word holds the last rows of one column, newest in the low byte.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      line_mem[s1_col_q] <= col_word;
    end
    if (pix_acc) begin
      rdata_q <= line_mem[col_q];
    end
  end

  assign col_word = LINE_W'({rdata_q, s1_pix_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= pix_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_row_q <= row_q;
      s1_col_q <= col_q;
      s1_pix_q <= pixel_i;
    end
  end

  assign s1_emit = (s1_row_q >= CNT_W'(KERNEL_DIM - 1)) &&
                   (s1_col_q >= CNT_W'(KERNEL_DIM - 1));
  assign s1_last = (s1_row_q == CNT_W'(IMAGE_SIZE - 1)) &&
                   (s1_col_q == CNT_W'(IMAGE_SIZE - 1));
  assign s1_orow_ext = EXT_W'(s1_row_q) - EXT_W'(KERNEL_DIM - 1);
  assign s1_ocol_ext = EXT_W'(s1_col_q) - EXT_W'(KERNEL_DIM - 1);

  // Window after the shift, and its products with the current kernel.
  always_comb begin
    for (int t = 0; t < KERNEL_DIM; t++) begin
      for (int x = 0; x < KERNEL_DIM - 1; x++) begin
        win_d[t][x] = win_q[t][x + 1];
      end
      win_d[t][KERNEL_DIM - 1] = col_word[PIX_W * (KERNEL_DIM - 1 - t) +: PIX_W];
      for (int x = 0; x < KERNEL_DIM; x++) begin
        prod_d[t][x] = PROD_W'(kern_q[t * KERNEL_DIM + x]) *
                       PROD_W'($signed({1'b0, win_d[t][x]}));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        kern_q[i] <= (i == CENTER) ? COEF_W'(1) : '0;
      end
    end else if (coef_we) begin
      for (int i = 0; i < TAPS; i++) begin
        if (int'(coef_index_i) == i) begin
          kern_q[i] <= coef_value_i;
        end
      end
    end
  end

  // Products.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (rdy2) begin
      s2_valid_q <= s1_adv && s1_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && s1_adv && s1_emit) begin
      prod_q    <= prod_d;
      s2_row_q  <= s1_orow_ext[COORD_W-1:0];
      s2_col_q  <= s1_ocol_ext[COORD_W-1:0];
      s2_last_q <= s1_last;
    end
  end

  // Row sums.
  always_comb begin
    for (int t = 0; t < KERNEL_DIM; t++) begin
      rsum_d[t] = '0;
      for (int x = 0; x < KERNEL_DIM; x++) begin
        rsum_d[t] = rsum_d[t] + ROW_W'(prod_q[t][x]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (rdy3) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && s2_valid_q) begin
      rsum_q    <= rsum_d;
      s3_row_q  <= s2_row_q;
      s3_col_q  <= s2_col_q;
      s3_last_q <= s2_last_q;
    end
  end

  // Total and output register.
  always_comb begin
    total_d = '0;
    for (int t = 0; t < KERNEL_DIM; t++) begin
      total_d = total_d + TOT_W'(rsum_q[t]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy4) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && s3_valid_q) begin
      sum_q      <= total_d[SUM_W-1:0];
      out_row_q  <= s3_row_q;
      out_col_q  <= s3_col_q;
      out_last_q <= s3_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sum_o       = sum_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign frame_end_o = out_last_q;

  `CV_ASSERT_IMP(a_mem_no_collision, pix_acc && s1_adv, col_q != s1_col_q)
  `CV_ASSERT_IMP(a_stall_has_cause, !in_ready_o, s1_valid_q && s2_valid_q)
  `CV_ASSERT_NXT(a_emit_reaches_s2, s1_adv && s1_emit, s2_valid_q)
  `CV_ASSERT_IMP(a_frame_end_pos, out_valid_o && frame_end_o,
                 (out_row_o == COORD_W'(IMAGE_SIZE - KERNEL_DIM)) &&
                 (out_col_o == COORD_W'(IMAGE_SIZE - KERNEL_DIM)))

endmodule
